/* src/i8mm_pkg.sv */
// Shared types, sizes and codes for the int8 matrix multiply block.
// Used by int8_matrix_multiply; depends on nothing else.
package i8mm_pkg;

  // Store geometry
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int MAX_INNER  = 256;
  localparam int ROW_BITS   = $clog2(MAX_ROWS);
  localparam int COL_BITS   = $clog2(MAX_COLS);
  localparam int INNER_BITS = $clog2(MAX_INNER);
  localparam int A_DEPTH    = MAX_ROWS * MAX_INNER;
  localparam int B_DEPTH    = MAX_INNER * MAX_COLS;

  // Field and register widths
  localparam int ELEM_W  = 8;
  localparam int PROD_W  = 16;
  localparam int ACC_W   = 24;
  localparam int ROWS_W  = 7;
  localparam int COLS_W  = 7;
  localparam int INNER_W = 9;

  // Register reset values
  localparam logic [ROWS_W-1:0]  ROWS_RESET  = ROWS_W'(64);
  localparam logic [COLS_W-1:0]  COLS_RESET  = COLS_W'(64);
  localparam logic [INNER_W-1:0] INNER_RESET = INNER_W'(256);

  // Item kinds
  localparam logic [1:0] KIND_WRITE_A = 2'd0;
  localparam logic [1:0] KIND_WRITE_B = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_INNER = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

/* src/int8_matrix_multiply.sv */
// Top level of the int8 matrix multiply block: A and B element stores,
// one multiply-accumulate unit, output register and APB register file.
// Depends on i8mm_pkg and i8mm_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item: kind,
//   row_index, col_index, element_value. Kind 0 writes A[row][inner],
//   kind 1 writes B[inner][col], kind 2 requests C[row][col], kind 3 is
//   dropped. Writes outside the configured sizes are dropped.
//   Output channel (out_valid / out_stall) returns one word per compute:
//   dot_result and index_error. An out-of-range compute returns 0 with
//   index_error set.
//   A compute walks the inner length through one MAC fed by the two store
//   read ports, with one A read and one B read per cycle. An out-of-range
//   compute goes straight to the done state without a MAC walk and
//   returns its word through the output register.
//   The input stalls while a compute runs or waits for the output register;
//   writes are still taken while a finished result waits on a stalled
//   receiver. Reset clears control and restores the registers to 64, 64,
//   256; store contents are undefined until written.
module int8_matrix_multiply (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  row_index,
  input  logic [7:0]  col_index,
  input  logic signed [7:0] element_value,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [23:0] dot_result,
  output logic        index_error,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW_A = $clog2(i8mm_pkg::A_DEPTH);
  localparam int AW_B = $clog2(i8mm_pkg::B_DEPTH);

  // Configuration registers
  logic [i8mm_pkg::ROWS_W-1:0]  rows_used;
  logic [i8mm_pkg::COLS_W-1:0]  cols_used;
  logic [i8mm_pkg::INNER_W-1:0] inner_length;

  // Effective sizes, saturated at the store maximums
  logic [i8mm_pkg::ROWS_W-1:0]  nrows;
  logic [i8mm_pkg::COLS_W-1:0]  ncols;
  logic [i8mm_pkg::INNER_W-1:0] ninner;

  // Control
  i8mm_pkg::state_t state, state_next;
  logic in_accept, out_accept, out_free;
  logic row_ok, col_ok, inner_row_ok, inner_col_ok;
  logic cmp_bad;
  logic issue, issue_done, run_done;

  // Datapath registers
  logic [i8mm_pkg::ROW_BITS-1:0]  row_reg;
  logic [i8mm_pkg::COL_BITS-1:0]  col_reg;
  logic [i8mm_pkg::INNER_W-1:0]   issue_cnt;
  logic                           rd_vld;
  logic                           prod_vld;
  logic signed [i8mm_pkg::PROD_W-1:0] prod;
  logic signed [i8mm_pkg::ACC_W-1:0]  acc;
  logic                           err_flag;

  // Store ports
  logic            a_we, b_we;
  logic [AW_A-1:0] a_waddr, a_raddr;
  logic [AW_B-1:0] b_waddr, b_raddr;
  logic [i8mm_pkg::ELEM_W-1:0] a_rdata, b_rdata;

  logic cfg_we;

  // Saturate sizes
  assign nrows  = (rows_used > i8mm_pkg::ROWS_W'(i8mm_pkg::MAX_ROWS))
                  ? i8mm_pkg::ROWS_W'(i8mm_pkg::MAX_ROWS) : rows_used;
  assign ncols  = (cols_used > i8mm_pkg::COLS_W'(i8mm_pkg::MAX_COLS))
                  ? i8mm_pkg::COLS_W'(i8mm_pkg::MAX_COLS) : cols_used;
  assign ninner = (inner_length > i8mm_pkg::INNER_W'(i8mm_pkg::MAX_INNER))
                  ? i8mm_pkg::INNER_W'(i8mm_pkg::MAX_INNER) : inner_length;

  // Range checks on the incoming word
  assign row_ok       = {1'b0, row_index} < {2'b0, nrows};
  assign col_ok       = {1'b0, col_index} < {2'b0, ncols};
  assign inner_row_ok = {1'b0, row_index} < ninner;
  assign inner_col_ok = {1'b0, col_index} < ninner;
  assign cmp_bad      = !(row_ok && col_ok);

  // Handshakes
  assign in_stall   = (state != i8mm_pkg::ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign out_free   = !out_valid || !out_stall;

  // Store writes happen only while idle; reads only while running, so
  // the stall acts as the interlock between them.
  assign a_we    = in_accept && (kind == i8mm_pkg::KIND_WRITE_A) && row_ok && inner_col_ok;
  assign b_we    = in_accept && (kind == i8mm_pkg::KIND_WRITE_B) && inner_row_ok && col_ok;
  assign a_waddr = {row_index[i8mm_pkg::ROW_BITS-1:0], col_index[i8mm_pkg::INNER_BITS-1:0]};
  assign b_waddr = {row_index[i8mm_pkg::INNER_BITS-1:0], col_index[i8mm_pkg::COL_BITS-1:0]};
  assign a_raddr = {row_reg, issue_cnt[i8mm_pkg::INNER_BITS-1:0]};
  assign b_raddr = {issue_cnt[i8mm_pkg::INNER_BITS-1:0], col_reg};

  i8mm_ram #(
    .WIDTH (i8mm_pkg::ELEM_W),
    .DEPTH (i8mm_pkg::A_DEPTH)
  ) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (element_value),
    .re    (issue),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  i8mm_ram #(
    .WIDTH (i8mm_pkg::ELEM_W),
    .DEPTH (i8mm_pkg::B_DEPTH)
  ) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (element_value),
    .re    (issue),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Issue / drain status
  assign issue_done = (issue_cnt >= ninner);
  assign issue      = (state == i8mm_pkg::ST_RUN) && !issue_done;
  assign run_done   = issue_done && !rd_vld && !prod_vld;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i8mm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      i8mm_pkg::ST_IDLE: begin
        if (in_accept && (kind == i8mm_pkg::KIND_COMPUTE)) begin
          state_next = cmp_bad ? i8mm_pkg::ST_DONE : i8mm_pkg::ST_RUN;
        end
      end
      i8mm_pkg::ST_RUN: begin
        if (run_done) begin
          state_next = i8mm_pkg::ST_DONE;
        end
      end
      i8mm_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = i8mm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = i8mm_pkg::ST_IDLE;
      end
    endcase
  end

  // Capture the request and run the MAC pipeline
  always_ff @(posedge clk) begin
    if (in_accept && (kind == i8mm_pkg::KIND_COMPUTE)) begin
      row_reg   <= row_index[i8mm_pkg::ROW_BITS-1:0];
      col_reg   <= col_index[i8mm_pkg::COL_BITS-1:0];
      issue_cnt <= '0;
      acc       <= '0;
      err_flag  <= cmp_bad;
    end else begin
      if (issue) begin
        issue_cnt <= issue_cnt + i8mm_pkg::INNER_W'(1);
      end
      if (prod_vld) begin
        acc <= acc + {{(i8mm_pkg::ACC_W-i8mm_pkg::PROD_W){prod[i8mm_pkg::PROD_W-1]}}, prod};
      end
    end
    if (rd_vld) begin
      prod <= $signed({{(i8mm_pkg::PROD_W-i8mm_pkg::ELEM_W){a_rdata[i8mm_pkg::ELEM_W-1]}},
                       a_rdata})
            * $signed({{(i8mm_pkg::PROD_W-i8mm_pkg::ELEM_W){b_rdata[i8mm_pkg::ELEM_W-1]}},
                       b_rdata});
    end
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= issue;
      prod_vld <= rd_vld;
    end
  end

  // Output register: load from DONE, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == i8mm_pkg::ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == i8mm_pkg::ST_DONE) && out_free) begin
      dot_result  <= err_flag ? '0 : acc;
      index_error <= err_flag;
    end
  end

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used    <= i8mm_pkg::ROWS_RESET;
      cols_used    <= i8mm_pkg::COLS_RESET;
      inner_length <= i8mm_pkg::INNER_RESET;
    end else if (cfg_we) begin
      case (paddr[3:2])
        i8mm_pkg::REG_ROWS:  rows_used    <= pwdata[i8mm_pkg::ROWS_W-1:0];
        i8mm_pkg::REG_COLS:  cols_used    <= pwdata[i8mm_pkg::COLS_W-1:0];
        i8mm_pkg::REG_INNER: inner_length <= pwdata[i8mm_pkg::INNER_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      i8mm_pkg::REG_ROWS:  prdata = {{(32-i8mm_pkg::ROWS_W){1'b0}}, rows_used};
      i8mm_pkg::REG_COLS:  prdata = {{(32-i8mm_pkg::COLS_W){1'b0}}, cols_used};
      i8mm_pkg::REG_INNER: prdata = {{(32-i8mm_pkg::INNER_W){1'b0}}, inner_length};
      default:             prdata = '0;
    endcase
  end

  // Stores are never written while a compute is in flight
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    (state != i8mm_pkg::ST_IDLE) |-> !(a_we || b_we))
    else $error("store write during compute");

  // Read issue never walks past the inner length
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == i8mm_pkg::ST_RUN) |-> (issue_cnt <= ninner))
    else $error("issue count past inner length");

  // A flagged result always carries zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && index_error) |-> (dot_result == '0))
    else $error("flagged result not zero");

  // MAC pipeline is empty whenever the block is idle
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == i8mm_pkg::ST_IDLE) |-> !(rd_vld || prod_vld))
    else $error("MAC pipeline busy while idle");

endmodule

/* src/i8mm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// Stand-alone; no package dependencies.
module i8mm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
